>>> rtl/tmvmc_pkg.sv
// Package with shared types, constants and the palette of the text video memory controller.
package tmvmc_pkg;

    localparam int unsigned VideoMemoryBytes = 65536;
    localparam int unsigned TextRows = 24;
    localparam int unsigned AddrW = 16;
    localparam logic [AddrW-1:0] FontBase = 16'(VideoMemoryBytes - 8 * 256);
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [3:0] {
        K_SET_SRC = 4'd0,
        K_SET_DST = 4'd1,
        K_SET_LEN = 4'd2,
        K_READ    = 4'd3,
        K_WRITE   = 4'd4,
        K_WRITE_A = 4'd5,
        K_MOVE    = 4'd6,
        K_PIXEL   = 4'd7,
        K_CLEAR   = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MOVE  = 2'd2,
        OP_PIXEL = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        advance;
        logic [7:0]  data;
        logic        blank;
        logic        mode;
        logic [15:0] loc;
        logic [2:0]  gy;
        logic [2:0]  gx;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WR_RD,
        S_WR_CMP,
        S_MV_RD,
        S_MV_CMP,
        S_PX_CODE,
        S_PX_ATTR,
        S_PX_FONT,
        S_PX_LINE,
        S_OUT
    } t_state;

    localparam logic [0:0] RegVideoMode = 1'b0;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'h000080;
            4'd2:  c = 24'h008000;
            4'd3:  c = 24'h008080;
            4'd4:  c = 24'h800000;
            4'd5:  c = 24'h800080;
            4'd6:  c = 24'h808000;
            4'd7:  c = 24'hC0C0C0;
            4'd8:  c = 24'h808080;
            4'd9:  c = 24'h0000FF;
            4'd10: c = 24'h00FF00;
            4'd11: c = 24'h00FFFF;
            4'd12: c = 24'hFF0000;
            4'd13: c = 24'hFF00FF;
            4'd14: c = 24'hFFFF00;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/tmvmc_if.sv
// Valid/ready channel interfaces for requests and results.
interface tmvmc_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    modport source(output valid, kind, value, pixel_x, pixel_y, input ready);
    modport sink(input valid, kind, value, pixel_x, pixel_y, output ready);
endinterface

interface tmvmc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [23:0] pixel_color;
    logic        refresh_pending;
    modport source(output valid, read_data, pixel_color, refresh_pending, input ready);
    modport sink(input valid, read_data, pixel_color, refresh_pending, output ready);
endinterface

>>> rtl/text_mode_video_memory_controller_top.sv
// Top level of the text mode video memory controller.
// Items arrive on the request channel (kind, value, pixel_x, pixel_y) and
// results leave on the result channel, one for read and pixel kinds only.
// The front end keeps the pointers and turns items into engine commands that
// wait in a two-entry queue; the engine owns the 64 KiB video memory.
// Pointer items only update the front-end registers. A read passes through
// S_RD and S_OUT; a pixel through S_PX_CODE, S_PX_ATTR, S_PX_FONT, S_PX_LINE
// and S_OUT with three memory reads, and straight to S_OUT below the text rows.
// A write passes S_WR_RD and S_WR_CMP. A move copies length+1 bytes.
// After reset, and after a clear item, the engine sweeps the memory to zero
// one byte per cycle and accepts no item meanwhile.
// Items wait while the engine is busy so that moves see stable pointers.
// When the receiver stalls the result is held in the output register and
// no new item is accepted until it has been taken.
// The video_mode register sits at address 0 of the APB-style port.
module text_mode_video_memory_controller_top #(
    parameter int unsigned TEXT_ROWS = tmvmc_pkg::TextRows
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmvmc_req_if.sink   req,
    tmvmc_rsp_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic r_mode;
    logic push, pop, full, empty, busy, clr_req, clr_ack;
    tmvmc_pkg::t_cmd fcmd, qcmd;
    logic [47:0] ptrs;

    assign pready = 1'b1;
    assign prdata = (paddr == tmvmc_pkg::RegVideoMode) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (psel && penable && pwrite && paddr == tmvmc_pkg::RegVideoMode)
            r_mode <= pwdata[0];
    end

    tmvmc_front #(.TEXT_ROWS(TEXT_ROWS)) u_front (
        .i_clk, .i_rst_n, .req, .i_mode(r_mode), .i_busy(busy),
        .i_clear_ack(clr_ack), .o_clear_req(clr_req),
        .o_push(push), .o_cmd(fcmd), .o_ptrs(ptrs), .i_full(full)
    );

    tmvmc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(fcmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_cmd(qcmd)
    );

    tmvmc_engine u_engine (
        .i_clk, .i_rst_n, .i_empty(empty), .i_cmd(qcmd), .o_pop(pop),
        .i_ptrs(ptrs), .i_clear_req(clr_req), .o_clear_ack(clr_ack),
        .o_busy(busy), .rsp
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty)) else $error("queue underflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
endmodule

>>> rtl/tmvmc_queue.sv
// Small command queue between the front decoder and the memory engine.
module tmvmc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tmvmc_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output tmvmc_pkg::t_cmd  o_cmd
);
    localparam int unsigned PtrW = $clog2(tmvmc_pkg::QueueDepth);

    tmvmc_pkg::t_cmd r_mem [tmvmc_pkg::QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(tmvmc_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

>>> rtl/tmvmc_front.sv
// Front end: pointer registers and classification of items into engine commands.
module tmvmc_front #(
    parameter int unsigned TEXT_ROWS = tmvmc_pkg::TextRows
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tmvmc_req_if.sink        req,
    input  logic             i_mode,
    input  logic             i_busy,
    input  logic             i_clear_ack,
    output logic             o_clear_req,
    output logic             o_push,
    output tmvmc_pkg::t_cmd  o_cmd,
    output logic [47:0]      o_ptrs,
    input  logic             i_full
);
    logic [15:0] r_src, r_dst, r_len;
    logic        r_clear;
    logic        accept;
    logic [3:0]  kind;
    tmvmc_pkg::t_cmd cmd;
    logic [5:0]  cx;
    logic [4:0]  cy;

    assign kind        = req.kind;
    assign req.ready   = !i_full && !r_clear && !i_busy;
    assign accept      = req.valid && req.ready;
    assign o_clear_req = r_clear;

    always_comb begin
        cmd         = '0;
        cmd.mode    = i_mode;
        cmd.data    = req.value[7:0];
        cmd.blank   = (req.pixel_y >= 9'(TEXT_ROWS * 16));
        cy          = req.pixel_y[8:4];
        cmd.gy      = req.pixel_y[3:1];
        if (!i_mode) begin
            cx       = {1'b0, req.pixel_x[8:4]};
            cmd.gx   = req.pixel_x[3:1];
            cmd.loc  = {5'd0, cy, cx[4:0], 1'b0};
        end else begin
            cx       = req.pixel_x[8:3];
            cmd.gx   = req.pixel_x[2:0];
            cmd.loc  = {4'd0, cy, cx, 1'b0};
        end
        o_push = 1'b0;
        cmd.op = tmvmc_pkg::OP_READ;
        if (accept) begin
            unique case (kind)
                tmvmc_pkg::K_READ: begin
                    o_push = 1'b1;
                    cmd.loc = r_src;
                end
                tmvmc_pkg::K_WRITE, tmvmc_pkg::K_WRITE_A: begin
                    o_push = 1'b1;
                    cmd.op = tmvmc_pkg::OP_WRITE;
                    cmd.loc = r_dst;
                end
                tmvmc_pkg::K_MOVE: begin
                    o_push = 1'b1;
                    cmd.op = tmvmc_pkg::OP_MOVE;
                end
                tmvmc_pkg::K_PIXEL: begin
                    o_push = 1'b1;
                    cmd.op = tmvmc_pkg::OP_PIXEL;
                end
                default: o_push = 1'b0;
            endcase
        end
        o_cmd = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src   <= '0;
            r_dst   <= '0;
            r_len   <= '0;
            r_clear <= 1'b0;
        end else begin
            if (i_clear_ack) r_clear <= 1'b0;
            if (accept) begin
                unique case (kind)
                    tmvmc_pkg::K_SET_SRC: r_src <= req.value;
                    tmvmc_pkg::K_SET_DST: r_dst <= req.value;
                    tmvmc_pkg::K_SET_LEN: r_len <= req.value;
                    tmvmc_pkg::K_WRITE_A: r_dst <= r_dst + 16'd1;
                    tmvmc_pkg::K_CLEAR: begin
                        r_src   <= '0;
                        r_dst   <= '0;
                        r_len   <= '0;
                        r_clear <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Move pointers are sampled by the engine only when it starts a move.
    assign o_ptrs = {r_src, r_dst, r_len};
endmodule

>>> rtl/tmvmc_engine.sv
// Back end: video memory, clearing sweep, write/move/read/pixel sequencer and result register.
module tmvmc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tmvmc_pkg::t_cmd  i_cmd,
    output logic             o_pop,
    input  logic [47:0]      i_ptrs,
    input  logic             i_clear_req,
    output logic             o_clear_ack,
    output logic             o_busy,
    tmvmc_rsp_if.source      rsp
);
    tmvmc_pkg::t_state r_st, n_st;
    logic [7:0]  r_mem [tmvmc_pkg::VideoMemoryBytes];
    logic [7:0]  r_rd;
    logic [15:0] r_a, n_a, r_s, n_s, r_cnt, n_cnt;
    logic [15:0] r_clr;
    logic [7:0]  r_code, r_attr;
    tmvmc_pkg::t_cmd r_cmd;
    logic        r_changed;
    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic [23:0] r_ocolor;
    logic [15:0] rd_addr;
    logic        we;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic [3:0]  idx;
    logic        bitv;

    assign o_busy = (r_st != tmvmc_pkg::S_IDLE) || !i_empty || r_ovalid;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            tmvmc_pkg::S_CLEAR:   if (r_clr == 16'hFFFF) n_st = tmvmc_pkg::S_IDLE;
            tmvmc_pkg::S_IDLE: begin
                if (i_clear_req) n_st = tmvmc_pkg::S_CLEAR;
                else if (!i_empty && !r_ovalid) begin
                    unique case (i_cmd.op)
                        tmvmc_pkg::OP_READ:  n_st = tmvmc_pkg::S_RD;
                        tmvmc_pkg::OP_WRITE: n_st = tmvmc_pkg::S_WR_RD;
                        tmvmc_pkg::OP_MOVE:  n_st = tmvmc_pkg::S_MV_RD;
                        default: n_st = i_cmd.blank ? tmvmc_pkg::S_OUT
                                                    : tmvmc_pkg::S_PX_CODE;
                    endcase
                end
            end
            tmvmc_pkg::S_RD:      n_st = tmvmc_pkg::S_OUT;
            tmvmc_pkg::S_WR_RD:   n_st = tmvmc_pkg::S_WR_CMP;
            tmvmc_pkg::S_WR_CMP:  n_st = tmvmc_pkg::S_IDLE;
            tmvmc_pkg::S_MV_RD:   n_st = tmvmc_pkg::S_MV_CMP;
            tmvmc_pkg::S_MV_CMP:  n_st = (r_cnt == '0) ? tmvmc_pkg::S_IDLE
                                                       : tmvmc_pkg::S_MV_RD;
            tmvmc_pkg::S_PX_CODE: n_st = tmvmc_pkg::S_PX_ATTR;
            tmvmc_pkg::S_PX_ATTR: n_st = tmvmc_pkg::S_PX_FONT;
            tmvmc_pkg::S_PX_FONT: n_st = tmvmc_pkg::S_PX_LINE;
            tmvmc_pkg::S_PX_LINE: n_st = tmvmc_pkg::S_OUT;
            default:              n_st = tmvmc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_st == tmvmc_pkg::S_IDLE) && !i_clear_req && !i_empty && !r_ovalid;
        o_clear_ack = (r_st == tmvmc_pkg::S_CLEAR) && (r_clr == 16'hFFFF);
        n_a   = r_a;
        n_s   = r_s;
        n_cnt = r_cnt;
        rd_addr = r_a;
        we = 1'b0;
        wa = r_a;
        wd = r_cmd.data;
        if (o_pop) begin
            n_a = i_cmd.loc;
            if (i_cmd.op == tmvmc_pkg::OP_MOVE) begin
                n_s   = i_ptrs[47:32];
                n_a   = i_ptrs[31:16];
                n_cnt = i_ptrs[15:0];
            end
        end
        unique case (r_st)
            tmvmc_pkg::S_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
                wd = '0;
            end
            tmvmc_pkg::S_WR_CMP: we = (r_rd != r_cmd.data);
            tmvmc_pkg::S_MV_RD:  rd_addr = r_s;
            tmvmc_pkg::S_MV_CMP: begin
                rd_addr = r_a;
                we = 1'b1;
                wd = r_rd;
                n_a = r_a + 16'd1;
                n_s = r_s + 16'd1;
                n_cnt = r_cnt - 16'd1;
            end
            tmvmc_pkg::S_PX_ATTR: rd_addr = r_a | 16'd1;
            tmvmc_pkg::S_PX_FONT: rd_addr = tmvmc_pkg::FontBase + {5'd0, r_code, r_cmd.gy};
            default: rd_addr = r_a;
        endcase
        bitv = r_rd[3'd7 - r_cmd.gx];
        idx  = bitv ? r_attr[3:0] : r_attr[7:4];
    end

    // A move needs the old destination byte to keep the change flag exact.
    logic [7:0] r_old;
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[(r_st == tmvmc_pkg::S_MV_RD) ? r_s : rd_addr];
        r_old <= r_mem[r_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= tmvmc_pkg::S_CLEAR;
            r_clr     <= '0;
            r_changed <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == tmvmc_pkg::S_IDLE && i_clear_req) r_clr <= '0;
            else if (r_st == tmvmc_pkg::S_CLEAR) r_clr <= r_clr + 16'd1;
            if (r_st == tmvmc_pkg::S_CLEAR) r_changed <= 1'b0;
            else if (r_st == tmvmc_pkg::S_WR_CMP && r_rd != r_cmd.data) r_changed <= 1'b1;
            else if (r_st == tmvmc_pkg::S_MV_CMP && r_rd != r_old) r_changed <= 1'b1;
            if (rsp.valid && rsp.ready) r_ovalid <= 1'b0;
            if (r_st == tmvmc_pkg::S_OUT) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_s <= n_s;
        r_cnt <= n_cnt;
        if (o_pop) r_cmd <= i_cmd;
        if (r_st == tmvmc_pkg::S_PX_ATTR) r_code <= r_rd;
        if (r_st == tmvmc_pkg::S_PX_FONT) r_attr <= r_rd;
        if (r_st == tmvmc_pkg::S_OUT && r_cmd.op == tmvmc_pkg::OP_READ) begin
            r_odata  <= r_rd;
            r_ocolor <= '0;
        end else if (r_st == tmvmc_pkg::S_PX_LINE) begin
            r_odata  <= '0;
            r_ocolor <= tmvmc_pkg::palette(idx);
        end else if (r_st == tmvmc_pkg::S_IDLE && o_pop && i_cmd.blank) begin
            r_odata  <= '0;
            r_ocolor <= '0;
        end
    end

    assign rsp.valid           = r_ovalid;
    assign rsp.read_data       = r_odata;
    assign rsp.pixel_color     = r_ocolor;
    assign rsp.refresh_pending = r_changed;
endmodule

>>> bench/tb_text_mode_video_memory_controller_top.sv
// Testbench for the text mode video memory controller: random access stream checked against a local model.
module tb_text_mode_video_memory_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [8:0]  px;
        logic [8:0]  py;
    } t_access;

    typedef struct packed {
        logic [7:0]  rd;
        logic [23:0] color;
        logic        refresh;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tmvmc_req_if req();
    tmvmc_rsp_if rsp();

    text_mode_video_memory_controller_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the controller state.
    logic [7:0]  vram [0:65535];
    logic [15:0] src_ptr, dst_ptr, mv_len;
    logic        dirty;
    logic        mode_q;

    t_access pending_accesses[$];
    t_answer expected_answers[$];
    int errors = 0;
    int answers_seen = 0;
    int idle_cycles = 0;
    int accepted = 0;
    int moves_done = 0, pixels_done = 0;
    int hold_left = 0;
    bit stall_long = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic poke(input logic [15:0] a, input logic [7:0] v);
        if (vram[a] != v) begin
            vram[a] = v;
            dirty = 1'b1;
        end
    endtask

    function automatic logic [23:0] pixel_color_of(input logic [8:0] x, input logic [8:0] y);
        logic [15:0] cell_a, fa;
        logic [7:0] code, attr, line;
        logic [2:0] gx, gy;
        logic [3:0] idx;
        if (y >= tmvmc_pkg::TextRows * 16) return 24'h0;
        gy = y[3:1];
        if (!mode_q) begin
            gx = x[3:1];
            cell_a = 16'((y[8:4] * 32 + x[8:4]) * 2);
        end else begin
            gx = x[2:0];
            cell_a = 16'((y[8:4] * 64 + x[8:3]) * 2);
        end
        code = vram[cell_a];
        attr = vram[16'(cell_a + 1)];
        fa = 16'(tmvmc_pkg::FontBase + 16'(code) * 8 + gy);
        line = vram[fa];
        idx = line[7 - gx] ? attr[3:0] : attr[7:4];
        case (idx)
            4'd0: return 24'h000000;  4'd1: return 24'h000080;
            4'd2: return 24'h008000;  4'd3: return 24'h008080;
            4'd4: return 24'h800000;  4'd5: return 24'h800080;
            4'd6: return 24'h808000;  4'd7: return 24'hC0C0C0;
            4'd8: return 24'h808080;  4'd9: return 24'h0000FF;
            4'd10: return 24'h00FF00; 4'd11: return 24'h00FFFF;
            4'd12: return 24'hFF0000; 4'd13: return 24'hFF00FF;
            4'd14: return 24'hFFFF00; default: return 24'hFFFFFF;
        endcase
    endfunction

    task automatic predict_access(input t_access a);
        logic [15:0] s, d;
        t_answer ans;
        case (a.kind)
            tmvmc_pkg::K_SET_SRC: src_ptr = a.value;
            tmvmc_pkg::K_SET_DST: dst_ptr = a.value;
            tmvmc_pkg::K_SET_LEN: mv_len = a.value;
            tmvmc_pkg::K_READ: begin
                ans.rd = vram[src_ptr]; ans.color = '0; ans.refresh = dirty;
                expected_answers.push_back(ans);
            end
            tmvmc_pkg::K_WRITE: poke(dst_ptr, a.value[7:0]);
            tmvmc_pkg::K_WRITE_A: begin
                poke(dst_ptr, a.value[7:0]);
                dst_ptr++;
            end
            tmvmc_pkg::K_MOVE: begin
                s = src_ptr; d = dst_ptr;
                for (int n = 0; n <= mv_len; n++) begin
                    poke(d, vram[s]);
                    s++; d++;
                end
                moves_done++;
            end
            tmvmc_pkg::K_PIXEL: begin
                ans.rd = '0; ans.color = pixel_color_of(a.px, a.py); ans.refresh = dirty;
                expected_answers.push_back(ans);
                pixels_done++;
            end
            tmvmc_pkg::K_CLEAR: begin
                foreach (vram[i]) vram[i] = 8'h0;
                src_ptr = '0; dst_ptr = '0; mv_len = '0; dirty = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of offers with random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            req.kind <= '0; req.value <= '0; req.pixel_x <= '0; req.pixel_y <= '0;
        end else begin
            if (req.valid && req.ready) begin
                predict_access(pending_accesses.pop_front());
                accepted++;
            end
            if (req.valid && !req.ready) begin
                // Keep the current offer.
            end else if (gap_left > 0) begin
                gap_left--;
                req.valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                req.valid <= 1'b1;
                req.kind <= pending_accesses[0].kind;
                req.value <= pending_accesses[0].value;
                req.pixel_x <= pending_accesses[0].px;
                req.pixel_y <= pending_accesses[0].py;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall pattern; a long hold is counted down here.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_answer w;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    report("unexpected result", 32'(rsp.pixel_color), 32'h0);
                end else begin
                    w = expected_answers.pop_front();
                    if (rsp.read_data !== w.rd)
                        report("read_data", 32'(rsp.read_data), 32'(w.rd));
                    if (rsp.pixel_color !== w.color)
                        report("pixel_color", 32'(rsp.pixel_color), 32'(w.color));
                    if (rsp.refresh_pending !== w.refresh)
                        report("refresh_pending", 32'(rsp.refresh_pending), 32'(w.refresh));
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if (stall_long) begin
                rsp.ready <= (stall_phase % 3 != 0) && ($urandom_range(0, 3) != 0);
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item or taken result, outside a long hold.
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n || hold_left > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("watchdog expired");
            $display("tb_text_mode_video_memory_controller_top: FAIL");
            $finish;
        end
    end

    task automatic add(input logic [3:0] k, input logic [15:0] v,
                       input logic [8:0] x = 0, input logic [8:0] y = 0);
        t_access a;
        a.kind = k; a.value = v; a.px = x; a.py = y;
        pending_accesses.push_back(a);
    endtask

    task automatic drain();
        wait (pending_accesses.size() == 0 && !req.valid);
        wait (expected_answers.size() == 0);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= tmvmc_pkg::RegVideoMode; pwdata <= {31'h0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode_q = m;
    endtask

    // Random pixel-oriented or memory-oriented content, mostly near the text page.
    task automatic random_access();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) add(tmvmc_pkg::K_SET_SRC, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 3071)));
        else if (r < 16) add(tmvmc_pkg::K_SET_DST, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                              : (($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3071))
                                 : 16'(tmvmc_pkg::FontBase + $urandom_range(0, 2047))));
        else if (r < 20) add(tmvmc_pkg::K_SET_LEN,
                             ($urandom_range(0, 40) == 0) ? 16'($urandom_range(0, 600))
                                                          : 16'($urandom_range(0, 8)));
        else if (r < 32) add(tmvmc_pkg::K_READ, 16'($urandom));
        else if (r < 40) add(tmvmc_pkg::K_WRITE, 16'($urandom));
        else if (r < 62) add(tmvmc_pkg::K_WRITE_A, 16'($urandom));
        else if (r < 66) add(tmvmc_pkg::K_MOVE, 16'($urandom));
        else if (r < 97) add(tmvmc_pkg::K_PIXEL, 16'($urandom), 9'($urandom),
                             9'($urandom_range(0, 400)));
        else add(4'($urandom_range(9, 15)), 16'($urandom), 9'($urandom), 9'($urandom));
    endtask

    initial begin
        src_ptr = '0; dst_ptr = '0; mv_len = '0; dirty = 1'b0; mode_q = 1'b0;
        foreach (vram[i]) vram[i] = 8'h0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pointers, writes to text and font, moves with wrap, pixels, unused kinds.
        add(tmvmc_pkg::K_READ, 16'h0);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd0, 9'd0);
        add(tmvmc_pkg::K_SET_DST, 16'h0000);
        add(tmvmc_pkg::K_WRITE_A, 16'h0041);
        add(tmvmc_pkg::K_WRITE_A, 16'hFF1E);
        add(tmvmc_pkg::K_SET_DST, 16'(tmvmc_pkg::FontBase + 8 * 8'h41));
        add(tmvmc_pkg::K_WRITE_A, 16'h00A5);
        add(tmvmc_pkg::K_WRITE_A, 16'h005A);
        add(tmvmc_pkg::K_WRITE, 16'h005A);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd0, 9'd0);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd2, 9'd2);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd511, 9'd383);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd5, 9'd384);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd511, 9'd511);
        add(tmvmc_pkg::K_SET_SRC, 16'hFFFE);
        add(tmvmc_pkg::K_SET_DST, 16'hFFFF);
        add(tmvmc_pkg::K_SET_LEN, 16'd3);
        add(tmvmc_pkg::K_MOVE, 16'h0);
        add(tmvmc_pkg::K_READ, 16'h0);
        add(tmvmc_pkg::K_SET_SRC, 16'h0000);
        add(tmvmc_pkg::K_READ, 16'h0);
        add(4'd15, 16'hFFFF, 9'h1FF, 9'h1FF);
        add(4'd9, 16'h0);
        drain();

        write_mode(1'b1);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd0, 9'd0);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd7, 9'd1);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd511, 9'd383);
        for (int i = 0; i < 600; i++) random_access();
        drain();

        // Receiver held off while the sender keeps offering.
        write_mode(1'b0);
        for (int i = 0; i < 40; i++)
            add(tmvmc_pkg::K_PIXEL, 16'h0, 9'($urandom), 9'($urandom_range(0, 383)));
        hold_left = 300;
        wait (hold_left == 0);
        stall_long = 1'b1;
        for (int i = 0; i < 600; i++) random_access();
        drain();

        write_mode(1'b1);
        stall_long = 1'b0;
        for (int i = 0; i < 700; i++) random_access();
        add(tmvmc_pkg::K_CLEAR, 16'h0);
        add(tmvmc_pkg::K_READ, 16'h0);
        add(tmvmc_pkg::K_PIXEL, 16'h0, 9'd100, 9'd100);
        for (int i = 0; i < 60; i++) random_access();
        drain();
        write_mode(1'b0);

        $display("covered %0d items, %0d results, %0d moves and %0d pixel fetches in both modes",
                 accepted, answers_seen, moves_done, pixels_done);
        if (errors == 0 && expected_answers.size() == 0)
            $display("tb_text_mode_video_memory_controller_top: PASS");
        else
            $display("tb_text_mode_video_memory_controller_top: FAIL");
        $finish;
    end
endmodule
